>>> hw/rtl/phb_pkg.sv
// Shared types and constants for the path history buffer.
`default_nettype none
package phb_pkg;
   localparam int TRAIL_DEPTH = 256;
   localparam int FRAC_BITS = 16;
   localparam logic [31:0] MIN_SPACING_RESET = 32'd65536;
   localparam logic [33:0] MAX_LENGTH_RESET = 34'd327680;
   localparam logic [0:0] REG_MIN_SPACING = 1'b0;
   localparam logic [0:0] REG_MAX_LENGTH = 1'b1;
   localparam int ROOT_BITS = 34;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [8:0]  stored_points;
      logic [33:0] arc_length;
      logic [8:0]  trimmed_count;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic rd_newest;
      logic diff_start;
      logic square_step;
      logic root_start;
      logic root_step;
      logic write_new;
      logic write_first;
      logic drop_full;
      logic rd_next;
      logic drop_step;
      logic clear_counts;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic regs_zero;
      logic far_enough;
      logic root_done;
      logic square_done;
      logic over_length;
   } status_type;
endpackage
`default_nettype wire

>>> hw/rtl/path_history_buffer_top.sv
// Top level of the path history buffer.
`default_nettype none
// One position is taken at a time and gives one result. A position that
// starts an empty trail, or that meets a zero register, goes straight to
// its result. Any other position reads the newest point, forms the
// differences, runs the three squarings, starts and runs the bit-serial
// square root and then decides. An accepted position first drops the
// oldest point when the store is full and then trims oldest points for
// length. A result still waiting for rsp_ready holds the next position
// before its result is loaded. The four 256-entry stores need no clearing
// after reset, since no value read from an entry is used before that
// entry was written.
module path_history_buffer_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire phb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output phb_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [63:0]      pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);
   phb_pkg::cmd_type cmd;
   phb_pkg::status_type status;
   logic [31:0] min_spacing;
   logic [33:0] max_length;
   logic cfg_we;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[2:0] == 3'd0) && (paddr[3:3] <= 1'b1);
   assign prdata = (paddr[3] == phb_pkg::REG_MIN_SPACING) ? {32'd0, min_spacing}
                                                          : {30'd0, max_length};

   phb_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   phb_datapath u_datapath (
      .clock, .reset, .cmd, .status, .req_data,
      .cfg_we, .cfg_sel(paddr[3]), .cfg_value(pwdata[33:0]),
      .min_spacing, .max_length, .rsp_out(rsp_data)
   );
endmodule
`default_nettype wire

>>> hw/rtl/phb_datapath.sv
// Datapath of the path history buffer: stores, distance, square root and trimming.
`default_nettype none
module phb_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire phb_pkg::cmd_type    cmd,
   output phb_pkg::status_type      status,
   input  wire phb_pkg::req_type    req_data,
   input  wire logic                cfg_we,
   input  wire logic                cfg_sel,
   input  wire logic [33:0]         cfg_value,
   output logic [31:0]              min_spacing,
   output logic [33:0]              max_length,
   output phb_pkg::rsp_type         rsp_out
);
   localparam int CNT_W = $clog2(phb_pkg::TRAIL_DEPTH + 1);
   localparam int IDX_W = $clog2(phb_pkg::TRAIL_DEPTH);

   logic [31:0] x_mem [phb_pkg::TRAIL_DEPTH];
   logic [31:0] y_mem [phb_pkg::TRAIL_DEPTH];
   logic [31:0] z_mem [phb_pkg::TRAIL_DEPTH];
   logic [33:0] seg_mem [phb_pkg::TRAIL_DEPTH];

   logic [31:0] min_ff;
   logic [33:0] max_ff;
   logic [IDX_W-1:0] oldest_ff;
   logic [CNT_W-1:0] total_ff;
   logic [35:0] arc_ff;
   phb_pkg::req_type pos_ff;
   logic [31:0] rx_ff, ry_ff, rz_ff;
   logic [33:0] rseg_ff;
   logic [32:0] d_ff [3];
   logic [1:0] sq_ff;
   logic [67:0] sum_ff;
   logic [33:0] root_ff;
   logic [5:0] bit_ff;
   logic root_done_ff;
   logic accepted_ff, overflow_ff;
   logic [CNT_W-1:0] trimmed_ff;
   phb_pkg::rsp_type rsp_ff;

   logic [IDX_W-1:0] newest_idx, append_idx, next_idx;
   logic [32:0] cur_d;
   logic [65:0] sq;
   logic [33:0] cand;
   logic [67:0] cand_sq;

   assign newest_idx = IDX_W'(oldest_ff + IDX_W'(total_ff - CNT_W'(1)));
   assign append_idx = IDX_W'(oldest_ff + IDX_W'(total_ff));
   assign next_idx = IDX_W'(oldest_ff + IDX_W'(1));
   assign cur_d = d_ff[sq_ff];
   assign sq = cur_d * cur_d;
   assign cand = root_ff | (34'd1 << bit_ff);
   assign cand_sq = cand * cand;

   always_ff @(posedge clock) begin
      if (cmd.rd_newest) begin
         rx_ff <= x_mem[newest_idx];
         ry_ff <= y_mem[newest_idx];
         rz_ff <= z_mem[newest_idx];
      end
      if (cmd.rd_next) begin
         rseg_ff <= seg_mem[next_idx];
      end
      if (cmd.write_new || cmd.write_first) begin
         x_mem[append_idx] <= pos_ff.pos_x;
         y_mem[append_idx] <= pos_ff.pos_y;
         z_mem[append_idx] <= pos_ff.pos_z;
         seg_mem[append_idx] <= cmd.write_first ? 34'd0 : root_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff <= req_data;
      end
      if (cmd.diff_start) begin
         d_ff[0] <= 33'(($signed({pos_ff.pos_x[31], pos_ff.pos_x}) - $signed({rx_ff[31], rx_ff})));
         d_ff[1] <= 33'(($signed({pos_ff.pos_y[31], pos_ff.pos_y}) - $signed({ry_ff[31], ry_ff})));
         d_ff[2] <= 33'(($signed({pos_ff.pos_z[31], pos_ff.pos_z}) - $signed({rz_ff[31], rz_ff})));
      end else if (cmd.square_step) begin
         d_ff[sq_ff] <= cur_d[32] ? 33'(-cur_d) : cur_d;
      end
      if (cmd.load_rsp) begin
         rsp_ff.accepted <= accepted_ff;
         rsp_ff.stored_points <= 9'(total_ff);
         rsp_ff.arc_length <= arc_ff[33:0];
         rsp_ff.trimmed_count <= 9'(trimmed_ff);
         rsp_ff.overflow <= overflow_ff;
      end
   end

   // Squaring takes two passes per axis: absolute value, then accumulate.
   logic sq_phase_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= phb_pkg::MIN_SPACING_RESET;
         max_ff <= phb_pkg::MAX_LENGTH_RESET;
         oldest_ff <= '0;
         total_ff <= '0;
         arc_ff <= '0;
         sq_ff <= '0;
         sq_phase_ff <= 1'b0;
         sum_ff <= '0;
         root_ff <= '0;
         bit_ff <= '0;
         root_done_ff <= 1'b0;
         accepted_ff <= 1'b0;
         overflow_ff <= 1'b0;
         trimmed_ff <= '0;
      end else begin
         if (cfg_we) begin
            if (cfg_sel == phb_pkg::REG_MIN_SPACING) begin
               min_ff <= cfg_value[31:0];
            end else begin
               max_ff <= cfg_value;
            end
         end
         if (cmd.clear_counts) begin
            accepted_ff <= 1'b0;
            overflow_ff <= 1'b0;
            trimmed_ff <= '0;
         end
         if (cmd.diff_start) begin
            sq_ff <= '0;
            sq_phase_ff <= 1'b0;
            sum_ff <= '0;
         end else if (cmd.square_step) begin
            sq_phase_ff <= 1'b1;
         end else if (sq_phase_ff && sq_ff != 2'd3) begin
            sum_ff <= sum_ff + 68'(sq);
            sq_ff <= sq_ff + 2'd1;
            sq_phase_ff <= 1'b0;
         end
         if (cmd.root_start) begin
            root_ff <= '0;
            bit_ff <= 6'(phb_pkg::ROOT_BITS - 1);
            root_done_ff <= 1'b0;
         end else if (cmd.root_step) begin
            if (cand_sq <= sum_ff) begin
               root_ff <= cand;
            end
            if (bit_ff == '0) begin
               root_done_ff <= 1'b1;
            end else begin
               bit_ff <= bit_ff - 6'd1;
            end
         end
         if (cmd.write_first) begin
            total_ff <= CNT_W'(1);
            accepted_ff <= 1'b1;
         end
         if (cmd.write_new) begin
            total_ff <= total_ff + CNT_W'(1);
            arc_ff <= arc_ff + 36'(root_ff);
            accepted_ff <= 1'b1;
         end
         if (cmd.drop_full || cmd.drop_step) begin
            arc_ff <= arc_ff - 36'(rseg_ff);
            oldest_ff <= next_idx;
            total_ff <= total_ff - CNT_W'(1);
            trimmed_ff <= trimmed_ff + CNT_W'(1);
         end
         if (cmd.drop_full) begin
            overflow_ff <= 1'b1;
         end
      end
   end

   assign status.empty = (total_ff == '0);
   assign status.full = (total_ff >= CNT_W'(phb_pkg::TRAIL_DEPTH));
   assign status.regs_zero = (min_ff == '0) || (max_ff == '0);
   assign status.far_enough = ({2'b00, min_ff} <= root_ff);
   assign status.root_done = root_done_ff;
   assign status.square_done = (sq_ff == 2'd3) && !sq_phase_ff;
   assign status.over_length = (total_ff > CNT_W'(1)) && (arc_ff > 36'(max_ff));
   assign min_spacing = min_ff;
   assign max_length = max_ff;
   assign rsp_out = rsp_ff;
endmodule
`default_nettype wire

>>> hw/rtl/phb_control.sv
// Controller state machine of the path history buffer.
`default_nettype none
module phb_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire phb_pkg::status_type status,
   output phb_pkg::cmd_type      cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_READ, S_DIFF, S_SQUARE, S_ROOT, S_DECIDE,
      S_FULLRD, S_FULLDROP, S_APPEND, S_TRIMRD, S_TRIM, S_DONE, S_OUT
   } state_type;

   state_type state_ff;
   logic rsp_valid_ff;
   logic sq_toggle_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            cmd.clear_counts = req_valid;
         end
         S_CHECK: cmd.rd_newest = 1'b1;
         S_READ: cmd.diff_start = 1'b1;
         S_SQUARE: cmd.square_step = !status.square_done && !sq_toggle_ff;
         S_DIFF: cmd.root_start = 1'b1;
         S_ROOT: cmd.root_step = !status.root_done;
         S_DECIDE: cmd.rd_next = 1'b1;
         S_FULLRD: cmd.rd_next = 1'b1;
         S_FULLDROP: cmd.drop_full = 1'b1;
         S_APPEND: cmd.write_new = 1'b1;
         S_TRIMRD: cmd.rd_next = 1'b1;
         S_TRIM: cmd.drop_step = status.over_length;
         S_DONE: cmd.load_rsp = !rsp_valid_ff;
         S_OUT: ;
         default: ;
      endcase
      if (state_ff == S_CHECK && !status.regs_zero && status.empty) begin
         cmd.write_first = 1'b1;
         cmd.rd_newest = 1'b0;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sq_toggle_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_CHECK;
            S_CHECK: begin
               if (status.regs_zero || status.empty) state_ff <= S_DONE;
               else state_ff <= S_READ;
            end
            S_READ: begin
               state_ff <= S_SQUARE;
               sq_toggle_ff <= 1'b0;
            end
            S_SQUARE: begin
               sq_toggle_ff <= !sq_toggle_ff;
               if (status.square_done) state_ff <= S_DIFF;
            end
            S_DIFF: state_ff <= S_ROOT;
            S_ROOT: if (status.root_done) state_ff <= S_DECIDE;
            S_DECIDE: begin
               if (!status.far_enough) state_ff <= S_DONE;
               else if (status.full) state_ff <= S_FULLDROP;
               else state_ff <= S_APPEND;
            end
            S_FULLRD: state_ff <= S_FULLDROP;
            S_FULLDROP: state_ff <= S_APPEND;
            S_APPEND: state_ff <= S_TRIMRD;
            S_TRIMRD: state_ff <= S_TRIM;
            S_TRIM: begin
               if (status.over_length) state_ff <= S_TRIMRD;
               else state_ff <= S_DONE;
            end
            S_DONE: if (!rsp_valid_ff) state_ff <= S_OUT;
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/phb_checker.sv
// Port-level checker for the path history buffer, bound to the top level.
`default_nettype none
module phb_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire phb_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result changed while stalled.");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Second transfer taken during work.");
   a_overflow_trim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.trimmed_count != 9'd0)
      else $error("Overflow without a dropped point.");
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |-> rsp_data.trimmed_count == 9'd0)
      else $error("Rejected position trimmed points.");
endmodule

bind path_history_buffer_top phb_checker u_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire
